// ===== rtl/evad_pkg.sv =====
// ---------------------------------------------------------------------------
// evad_pkg: shared types and codes for the energy voice activity detector
// field widths, register indexes, detector stages and chunk action codes
// ---------------------------------------------------------------------------
package evad_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int THRESH_W  = 15;
  localparam int COUNT_W   = 13;
  localparam int LIMIT_W   = 4;
  localparam int HANG_W    = 5;
  localparam int STAGE_W   = 3;
  localparam int ACTION_W  = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 15;

  // largest count the field can hold
  localparam int COUNT_MAX = 8191;

  typedef logic [STAGE_W-1:0]  stage_t;
  typedef logic [ACTION_W-1:0] action_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // register indexes
  localparam cfg_idx_t REG_AMP_THRESH = 3'd0;
  localparam cfg_idx_t REG_ONSET_MIN  = 3'd1;
  localparam cfg_idx_t REG_STRONG_MIN = 3'd2;
  localparam cfg_idx_t REG_HOLD_MIN   = 3'd3;
  localparam cfg_idx_t REG_SIL_LIMIT  = 3'd4;

  // detector stages
  localparam stage_t ST_IDLE   = 3'd0;
  localparam stage_t ST_CAND1  = 3'd1;
  localparam stage_t ST_CAND2  = 3'd2;
  localparam stage_t ST_CAND3  = 3'd3;
  localparam stage_t ST_SPEECH = 3'd4;

  // chunk actions
  localparam action_t ACT_DROP    = 3'd0;
  localparam action_t ACT_START   = 3'd1;
  localparam action_t ACT_APPEND  = 3'd2;
  localparam action_t ACT_FLUSH   = 3'd3;
  localparam action_t ACT_FORWARD = 3'd4;
  localparam action_t ACT_END     = 3'd5;

  // reset values of the registers
  localparam logic [THRESH_W-1:0] RST_AMP_THRESH = 15'd2000;
  localparam logic [COUNT_W-1:0]  RST_ONSET_MIN  = 13'd1;
  localparam logic [COUNT_W-1:0]  RST_STRONG_MIN = 13'd10;
  localparam logic [COUNT_W-1:0]  RST_HOLD_MIN   = 13'd5;
  localparam logic [LIMIT_W-1:0]  RST_SIL_LIMIT  = 4'd3;

  typedef struct packed {
    logic [COUNT_W-1:0] loud_count;
    stage_t             detect_state;
    action_t            chunk_action;
  } result_t;

endpackage

// ===== rtl/energy_voice_activity_detector_top.sv =====
// ---------------------------------------------------------------------------
// energy_voice_activity_detector_top: chunked energy vad with hangover
// counts loud samples per chunk and steps an onset / speech / hangover
// detector at each chunk end, giving one action code per finished chunk
// ---------------------------------------------------------------------------
// One sample is taken per clock while in_stall is low. The loud-sample count
// and the detector update are done in the cycle a request is accepted, and
// the chunk result is registered into the output register, or into the skid
// register while the output holds a result. A two-entry result buffer
// (output register plus skid register) keeps samples flowing while a result
// waits; in_stall rises only when both entries are full. A chunk that saw
// pause on any of its samples produces no result and leaves the detector
// untouched. Registers are written through cfg_ with cfg_ready always high;
// writes to indexes beyond the register list are ignored.
// ---------------------------------------------------------------------------
module energy_voice_activity_detector_top #(
  parameter int MAX_CHUNK = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // sample channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [evad_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                in_chunk_last,
  input  logic                                in_paused,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [evad_pkg::COUNT_W-1:0]        out_loud_count,
  output logic [evad_pkg::STAGE_W-1:0]        out_detect_state,
  output logic [evad_pkg::ACTION_W-1:0]       out_chunk_action,
  // register write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [evad_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [evad_pkg::CFG_DAT_W-1:0]      cfg_data
);

  // count saturates at the chunk size or at the field limit, whichever is less
  localparam int CAP_INT = (MAX_CHUNK > evad_pkg::COUNT_MAX) ? evad_pkg::COUNT_MAX
                                                              : MAX_CHUNK;
  localparam logic [evad_pkg::COUNT_W-1:0] COUNT_CAP = evad_pkg::COUNT_W'(CAP_INT);

  // configuration registers
  logic [evad_pkg::THRESH_W-1:0] amp_thresh_r;
  logic [evad_pkg::COUNT_W-1:0]  onset_min_r;
  logic [evad_pkg::COUNT_W-1:0]  strong_min_r;
  logic [evad_pkg::COUNT_W-1:0]  hold_min_r;
  logic [evad_pkg::LIMIT_W-1:0]  sil_limit_r;

  // detector state
  evad_pkg::stage_t             stage_r, stage_nxt;
  logic [evad_pkg::HANG_W-1:0]  hang_r, hang_nxt;
  logic [evad_pkg::COUNT_W-1:0] accum_r, accum_nxt;
  logic                         pause_seen_r, pause_seen_nxt;

  // result buffer
  evad_pkg::result_t out_r, skid_r, res;
  logic              out_valid_r, skid_valid_r;

  logic                         in_take, out_take, res_valid;
  logic                         pause_eff, loud;
  logic [evad_pkg::SAMPLE_W-1:0] mag;
  logic [evad_pkg::COUNT_W-1:0] cnt;
  logic [evad_pkg::HANG_W-1:0]  hang_hold;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign in_take   = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;

  // magnitude: -32768 maps to 32768, which still fits 16 unsigned bits
  assign mag  = in_sample[evad_pkg::SAMPLE_W-1] ? (~in_sample + 1'b1) : in_sample;
  assign loud = mag > {1'b0, amp_thresh_r};

  // count including the current sample
  assign cnt       = (loud && (accum_r < COUNT_CAP)) ? accum_r + 1'b1 : accum_r;
  assign pause_eff = pause_seen_r || in_paused;
  assign res_valid = in_take && in_chunk_last && !pause_eff;

  // hangover after a speech chunk, before the end check
  assign hang_hold = (cnt > hold_min_r) ? '0 :
                     (&hang_r) ? hang_r : hang_r + 1'b1;

  // detector step
  always_comb begin
    stage_nxt        = stage_r;
    hang_nxt         = hang_r;
    res.loud_count   = cnt;
    res.chunk_action = evad_pkg::ACT_DROP;
    unique case (stage_r)
      evad_pkg::ST_CAND1, evad_pkg::ST_CAND2: begin
        if (cnt > strong_min_r) begin
          stage_nxt        = stage_r + 1'b1;
          res.chunk_action = evad_pkg::ACT_APPEND;
        end else begin
          stage_nxt = evad_pkg::ST_IDLE;
        end
      end
      evad_pkg::ST_CAND3: begin
        if (cnt > strong_min_r) begin
          stage_nxt        = evad_pkg::ST_SPEECH;
          hang_nxt         = '0;
          res.chunk_action = evad_pkg::ACT_FLUSH;
        end else begin
          stage_nxt = evad_pkg::ST_IDLE;
        end
      end
      evad_pkg::ST_SPEECH: begin
        if (hang_hold > {1'b0, sil_limit_r}) begin
          stage_nxt        = evad_pkg::ST_IDLE;
          hang_nxt         = '0;
          res.chunk_action = evad_pkg::ACT_END;
        end else begin
          hang_nxt         = hang_hold;
          res.chunk_action = evad_pkg::ACT_FORWARD;
        end
      end
      default: begin
        // idle, and unused stage codes behave as idle
        if (cnt > onset_min_r) begin
          stage_nxt        = evad_pkg::ST_CAND1;
          res.chunk_action = evad_pkg::ACT_START;
        end else begin
          stage_nxt = evad_pkg::ST_IDLE;
        end
      end
    endcase
    res.detect_state = stage_nxt;
  end

  // chunk accumulator and pause mark, cleared at every chunk end
  always_comb begin
    accum_nxt      = accum_r;
    pause_seen_nxt = pause_seen_r;
    if (in_take) begin
      if (in_chunk_last) begin
        accum_nxt      = '0;
        pause_seen_nxt = 1'b0;
      end else begin
        accum_nxt      = cnt;
        pause_seen_nxt = pause_eff;
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amp_thresh_r <= evad_pkg::RST_AMP_THRESH;
      onset_min_r  <= evad_pkg::RST_ONSET_MIN;
      strong_min_r <= evad_pkg::RST_STRONG_MIN;
      hold_min_r   <= evad_pkg::RST_HOLD_MIN;
      sil_limit_r  <= evad_pkg::RST_SIL_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        evad_pkg::REG_AMP_THRESH: amp_thresh_r <= cfg_data;
        evad_pkg::REG_ONSET_MIN:  onset_min_r  <= cfg_data[evad_pkg::COUNT_W-1:0];
        evad_pkg::REG_STRONG_MIN: strong_min_r <= cfg_data[evad_pkg::COUNT_W-1:0];
        evad_pkg::REG_HOLD_MIN:   hold_min_r   <= cfg_data[evad_pkg::COUNT_W-1:0];
        evad_pkg::REG_SIL_LIMIT:  sil_limit_r  <= cfg_data[evad_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // detector state update; stage and hangover change only on an unpaused chunk end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r      <= evad_pkg::ST_IDLE;
      hang_r       <= '0;
      accum_r      <= '0;
      pause_seen_r <= 1'b0;
    end else begin
      accum_r      <= accum_nxt;
      pause_seen_r <= pause_seen_nxt;
      if (res_valid) begin
        stage_r <= stage_nxt;
        hang_r  <= hang_nxt;
      end
    end
  end

  // result buffer: output register with a skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      // input is stalled; drain skid into output when it moves
      if (out_take) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (!out_valid_r || out_take) begin
      out_valid_r <= res_valid;
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) begin
        out_r <= skid_r;
      end
    end else if (!out_valid_r || out_take) begin
      if (res_valid) begin
        out_r <= res;
      end
    end else if (res_valid) begin
      skid_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_loud_count   = out_r.loud_count;
  assign out_detect_state = out_r.detect_state;
  assign out_chunk_action = out_r.chunk_action;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench: self-checking bench for energy_voice_activity_detector_top
// drives sample chunks, register writes and random stalls, predicts every
// chunk result from a behavioural copy of the detector and checks each one
// ---------------------------------------------------------------------------
module testbench;
  import evad_pkg::*;

  localparam int MAX_CHUNK_TB = 4096;
  // the loud count stops at the chunk size or at the field maximum
  localparam int COUNT_CAP    = (MAX_CHUNK_TB > COUNT_MAX) ? COUNT_MAX : MAX_CHUNK_TB;
  localparam int HANG_MAX     = (1 << HANG_W) - 1;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int SHOWN_ERRORS = 10;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic                       in_chunk_last;
  logic                       in_paused;
  logic                       out_valid;
  logic                       out_stall;
  logic [COUNT_W-1:0]         out_loud_count;
  logic [STAGE_W-1:0]         out_detect_state;
  logic [ACTION_W-1:0]        out_chunk_action;
  logic                       cfg_valid;
  logic                       cfg_ready;
  cfg_idx_t                   cfg_index;
  logic [CFG_DAT_W-1:0]       cfg_data;

  // behavioural copy of the register file
  logic [THRESH_W-1:0] amp_thresh;
  logic [COUNT_W-1:0]  onset_min;
  logic [COUNT_W-1:0]  strong_min;
  logic [COUNT_W-1:0]  hold_min;
  logic [LIMIT_W-1:0]  sil_limit;

  // behavioural copy of the detector state
  stage_t              det_stage;
  logic [HANG_W-1:0]   hang_cnt;
  logic [COUNT_W-1:0]  loud_acc;
  bit                  pause_mark;

  // chunk results still owed by the block, oldest first
  result_t pending_results[$];

  int error_count;
  int samples_sent;
  int cycle_count;
  int stall_left;
  bit gaps_on;
  bit stalls_on;

  energy_voice_activity_detector_top #(
    .MAX_CHUNK(MAX_CHUNK_TB)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample       (in_sample),
    .in_chunk_last   (in_chunk_last),
    .in_paused       (in_paused),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_loud_count  (out_loud_count),
    .out_detect_state(out_detect_state),
    .out_chunk_action(out_chunk_action),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: a hung handshake or a lost result ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side back-pressure, in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (stalls_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 9);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= SHOWN_ERRORS) begin
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
    end
  endtask

  // result checker: every accepted result is matched against the oldest one owed
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        flag_error($sformatf("unexpected result count=%0d state=%0d action=%0d",
                             out_loud_count, out_detect_state, out_chunk_action));
      end else begin
        want = pending_results.pop_front();
        if (out_loud_count !== want.loud_count || out_detect_state !== want.detect_state ||
            out_chunk_action !== want.chunk_action) begin
          flag_error($sformatf({"expected count=%0d state=%0d action=%0d, ",
                                "got count=%0d state=%0d action=%0d"},
                               want.loud_count, want.detect_state, want.chunk_action,
                               out_loud_count, out_detect_state, out_chunk_action));
        end
      end
    end
  end

  task automatic restore_defaults();
    amp_thresh = RST_AMP_THRESH;
    onset_min  = RST_ONSET_MIN;
    strong_min = RST_STRONG_MIN;
    hold_min   = RST_HOLD_MIN;
    sil_limit  = RST_SIL_LIMIT;
    det_stage  = ST_IDLE;
    hang_cnt   = '0;
    loud_acc   = '0;
    pause_mark = 1'b0;
  endtask

  // one accepted sample through the detector; a finished, unpaused chunk owes a result
  task automatic step_detector(input logic [SAMPLE_W-1:0] level, input bit last, input bit p);
    int          mag;
    logic [COUNT_W-1:0] cnt;
    action_t     act;
    result_t     res;
    mag = level[SAMPLE_W-1] ? (1 << SAMPLE_W) - int'(level) : int'(level);
    if (p) pause_mark = 1'b1;
    if (mag > int'(amp_thresh) && int'(loud_acc) < COUNT_CAP) loud_acc++;
    if (last) begin
      cnt      = loud_acc;
      loud_acc = '0;
      if (pause_mark) begin
        // paused chunk: no result, detector left alone
        pause_mark = 1'b0;
      end else begin
        act = ACT_DROP;
        if (det_stage > ST_SPEECH) det_stage = ST_IDLE;
        case (det_stage)
          ST_IDLE: begin
            if (cnt > onset_min) begin
              det_stage = ST_CAND1;
              act       = ACT_START;
            end
          end
          ST_CAND1, ST_CAND2: begin
            if (cnt > strong_min) begin
              det_stage = det_stage + 1'b1;
              act       = ACT_APPEND;
            end else begin
              det_stage = ST_IDLE;
            end
          end
          ST_CAND3: begin
            if (cnt > strong_min) begin
              det_stage = ST_SPEECH;
              hang_cnt  = '0;
              act       = ACT_FLUSH;
            end else begin
              det_stage = ST_IDLE;
            end
          end
          default: begin
            if (cnt > hold_min) hang_cnt = '0;
            else if (int'(hang_cnt) < HANG_MAX) hang_cnt++;
            act = ACT_FORWARD;
            if (hang_cnt > sil_limit) begin
              det_stage = ST_IDLE;
              hang_cnt  = '0;
              act       = ACT_END;
            end
          end
        endcase
        res.loud_count   = cnt;
        res.detect_state = det_stage;
        res.chunk_action = act;
        pending_results.push_back(res);
      end
    end
  endtask

  // one sample request; valid is held until accepted and left high for the next one
  task automatic send_sample(input logic [SAMPLE_W-1:0] level, input bit last, input bit p);
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_sample     <= level;
    in_chunk_last <= last;
    in_paused     <= p;
    do @(posedge clk); while (in_stall);
    samples_sent++;
    step_detector(level, last, p);
  endtask

  // sender holds off until the block has delivered everything owed
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // margin for a paused chunk still in flight
    repeat (4) @(posedge clk);
  endtask

  // register write request; valid stays high so back-to-back writes stay clean
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DAT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_AMP_THRESH: amp_thresh = value[THRESH_W-1:0];
      REG_ONSET_MIN:  onset_min  = value[COUNT_W-1:0];
      REG_STRONG_MIN: strong_min = value[COUNT_W-1:0];
      REG_HOLD_MIN:   hold_min   = value[COUNT_W-1:0];
      REG_SIL_LIMIT:  sil_limit  = value[LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_registers(input logic [CFG_DAT_W-1:0] thr, input logic [CFG_DAT_W-1:0] onset,
                               input logic [CFG_DAT_W-1:0] strong_lvl,
                               input logic [CFG_DAT_W-1:0] hold,
                               input logic [CFG_DAT_W-1:0] limit);
    wait_idle();
    write_reg(REG_AMP_THRESH, thr);
    write_reg(REG_ONSET_MIN, onset);
    write_reg(REG_STRONG_MIN, strong_lvl);
    write_reg(REG_HOLD_MIN, hold);
    write_reg(REG_SIL_LIMIT, limit);
    cfg_valid <= 1'b0;
  endtask

  // a level that is loud or quiet against the current threshold, often at the edge
  function automatic logic [SAMPLE_W-1:0] pick_level(input bit loud);
    int                  mag;
    bit                  neg;
    logic [SAMPLE_W-1:0] lvl;
    neg = $urandom_range(0, 1);
    if (loud) begin
      mag = ($urandom_range(0, 7) == 0) ? int'(amp_thresh) + 1
                                         : $urandom_range(int'(amp_thresh) + 1, 1 << (SAMPLE_W-1));
      // full-scale magnitude only exists on the negative side
      if (mag == (1 << (SAMPLE_W-1))) neg = 1'b1;
    end else begin
      mag = ($urandom_range(0, 7) == 0) ? int'(amp_thresh) : $urandom_range(0, int'(amp_thresh));
    end
    lvl = mag[SAMPLE_W-1:0];
    if (neg) lvl = -lvl;
    return lvl;
  endfunction

  // a chunk of len samples, n_loud of them loud at random places
  task automatic send_chunk(input int len, input int n_loud, input int pause_at);
    int left_loud;
    bit loud;
    left_loud = n_loud;
    for (int i = 0; i < len; i++) begin
      loud = (left_loud > 0) && ($urandom_range(1, len - i) <= left_loud);
      if (loud) left_loud--;
      send_sample(pick_level(loud), i == len - 1, i == pause_at);
    end
  endtask

  // reset registers: level edges around the default threshold, then a short onset
  task automatic test_level_edges();
    logic [SAMPLE_W-1:0] edge_levels[8];
    edge_levels = '{16'd0, 16'd2000, 16'd2001, 16'(-2000), 16'(-2001),
                    16'h7FFF, 16'h8000, 16'hFFFF};
    foreach (edge_levels[i]) send_sample(edge_levels[i], 1'b1, 1'b0);
    send_chunk(2, 2, -1);
    send_chunk(2, 0, -1);
  endtask

  // the whole detector path with small thresholds, plus a failed onset
  task automatic test_detector_walk();
    set_registers(15'd100, 15'd0, 15'd1, 15'd1, 15'd1);
    send_chunk(2, 1, -1);   // start preroll
    send_chunk(3, 2, -1);   // append
    send_chunk(2, 2, -1);   // append
    send_chunk(3, 2, -1);   // flush and enter speech
    send_chunk(2, 1, -1);   // weak, hangover one
    send_chunk(2, 2, -1);   // strong, hangover cleared
    send_chunk(3, 3, 1);    // paused mid-speech, nothing changes
    send_chunk(1, 0, -1);   // hangover one
    send_chunk(2, 0, -1);   // hangover past limit, speech ends
    send_chunk(1, 1, -1);   // start again
    send_chunk(2, 1, -1);   // weak candidate falls back to idle
    send_chunk(1, 0, -1);
  endtask

  // register extremes, masking of wide writes and ignored indexes
  task automatic test_register_extremes();
    // threshold at full scale: only the most negative sample is loud
    set_registers(15'h7FFF, 15'd0, 15'd0, 15'h7FFF, 15'h7FFF);
    send_sample(16'h7FFF, 1'b1, 1'b0);
    repeat (4) send_sample(16'h8000, 1'b1, 1'b0);
    // hold minimum masked to its maximum: every speech chunk is weak
    repeat (17) send_sample(16'h0000, 1'b1, 1'b0);
    wait_idle();
    for (int k = int'(REG_SIL_LIMIT) + 1; k < (1 << CFG_IDX_W); k++) begin
      write_reg(cfg_idx_t'(k), 15'h0000);
    end
    cfg_valid <= 1'b0;
    send_sample(16'h8000, 1'b1, 1'b0);
    // zero threshold, onset out of reach
    set_registers(15'd0, 15'h7FFF, 15'h7FFF, 15'd0, 15'd0);
    send_sample(16'h0000, 1'b1, 1'b0);
    send_sample(16'h0001, 1'b1, 1'b0);
    send_sample(16'hFFFF, 1'b1, 1'b0);
    // silence limit zero: first weak speech chunk ends speech
    set_registers(15'd0, 15'd0, 15'd0, 15'd0, 15'h7FF0);
    repeat (5) send_sample(16'h0001, 1'b1, 1'b0);
    send_sample(16'h0000, 1'b1, 1'b0);
    send_sample(16'h0000, 1'b1, 1'b0);
  endtask

  // pause on first, last and only sample; paused chunks leave candidate and hangover alone
  task automatic test_paused_chunks();
    set_registers(15'd100, 15'd0, 15'd0, 15'd0, 15'd2);
    send_chunk(3, 3, 0);
    send_chunk(3, 3, 2);
    send_chunk(1, 1, 0);
    send_chunk(2, 1, -1);   // count starts afresh after a paused chunk
    send_chunk(2, 0, 1);    // weak but paused, candidate kept
    send_chunk(1, 1, -1);
    send_chunk(1, 1, -1);
    send_chunk(1, 1, -1);   // speech
    send_chunk(2, 0, 0);    // paused, no hangover step
    send_chunk(1, 0, -1);
    send_chunk(1, 0, -1);
    send_chunk(1, 0, -1);
  endtask

  // fully random samples with sparse pause bits
  task automatic send_noise_chunk();
    int len;
    len = $urandom_range(1, 12);
    for (int i = 0; i < len; i++) begin
      send_sample(SAMPLE_W'($urandom_range(0, (1 << SAMPLE_W) - 1)), i == len - 1,
                  $urandom_range(0, 15) == 0);
    end
  endtask

  // chunk aimed at the threshold that matters in the current stage
  task automatic send_steered_chunk();
    int bar;
    int target;
    int len;
    int pause_at;
    int pick;
    int strong_share;
    if (det_stage == ST_IDLE) bar = int'(onset_min);
    else if (det_stage == ST_SPEECH) bar = int'(hold_min);
    else bar = int'(strong_min);
    // weak chunks are more useful in speech, to reach the hangover end
    strong_share = (det_stage == ST_SPEECH) ? 9 : 14;
    pick = $urandom_range(0, 19);
    if (pick < 2) begin
      send_noise_chunk();
    end else begin
      if (pick < strong_share) target = bar + 1 + $urandom_range(0, 3);
      else if (pick < 18) target = $urandom_range(0, bar);
      else target = bar + $urandom_range(0, 1);
      if (target > 40) target = 40;
      len = target + $urandom_range(0, 4);
      if (len == 0) len = 1;
      pause_at = ($urandom_range(0, 11) == 0) ? $urandom_range(0, len - 1) : -1;
      send_chunk(len, target, pause_at);
    end
  endtask

  // random traffic over several settings; the last phase runs without gaps or stalls
  task automatic test_random_traffic();
    int stop_at;
    for (int phase = 0; phase < 4; phase++) begin
      set_registers(($urandom_range(0, 3) == 0) ? CFG_DAT_W'($urandom_range(0, 32767))
                                                 : CFG_DAT_W'($urandom_range(50, 4000)),
                    CFG_DAT_W'($urandom_range(0, 3)), CFG_DAT_W'($urandom_range(0, 5)),
                    CFG_DAT_W'($urandom_range(0, 5)), CFG_DAT_W'($urandom_range(0, 4)));
      if (phase == 3) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end
      stop_at = samples_sent + 300;
      while (samples_sent < stop_at) begin
        send_steered_chunk();
        // now and then the sender waits for the block to catch up
        if ($urandom_range(0, 39) == 0) wait_idle();
      end
    end
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_sample     <= '0;
    in_chunk_last <= 1'b0;
    in_paused     <= 1'b0;
    out_stall     <= 1'b0;
    cfg_valid     <= 1'b0;
    cfg_index     <= REG_AMP_THRESH;
    cfg_data      <= '0;
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    restore_defaults();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_level_edges();
    test_detector_walk();
    test_register_extremes();
    test_paused_chunks();
    test_random_traffic();

    wait_idle();
    repeat (16) @(posedge clk);
    if (error_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
